### hw/rtl/orcc_pkg.sv
// Package for the oriented rectangle collision check core.
// Holds pipeline depths, datapath widths and the item and geometry structs.
// Used by every module under hw/rtl; depends on nothing else.
package orcc_pkg;

  localparam int ISQRT_STAGES = 32;
  localparam int DIV_STAGES   = 17;
  localparam int UNIT_LAT     = ISQRT_STAGES + DIV_STAGES + 2;
  localparam int SIGN_DLY     = ISQRT_STAGES + DIV_STAGES;
  localparam int RECT_LAT     = 2;
  localparam int INSIDE_LAT   = 4;
  localparam int NEAR_LAT     = 6;
  localparam int D_DLY        = UNIT_LAT + RECT_LAT;
  localparam int HIT_LAT      = D_DLY + INSIDE_LAT;
  localparam int NEAR_DLY     = HIT_LAT - NEAR_LAT;
  localparam int TOTAL_LAT    = HIT_LAT + 1;

  localparam int QUO_W  = 17;
  localparam int HS_W   = 25;
  localparam int OFF_W  = 26;
  localparam int DIFF_W = 28;
  localparam int PROD_W = 54;

  localparam logic [QUO_W-1:0] UNIT_ONE = 17'd65536;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [15:0] a_dir_x;
    logic signed [15:0] a_dir_y;
    logic [15:0]        a_wide;
    logic [15:0]        a_long;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [15:0] b_dir_x;
    logic signed [15:0] b_dir_y;
    logic [15:0]        b_wide;
    logic [15:0]        b_long;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic near;
  } out_item_t;

  typedef struct packed {
    logic [QUO_W-1:0] x_mag;
    logic             x_neg;
    logic [QUO_W-1:0] y_mag;
    logic             y_neg;
  } unit_vec_t;

  typedef struct packed {
    logic [3:0][OFF_W-1:0] cx;
    logic [3:0][OFF_W-1:0] cy;
    logic [HS_W-1:0]       lx;
    logic [HS_W-1:0]       ly;
    logic [HS_W-1:0]       fx;
    logic [HS_W-1:0]       fy;
  } rect_geom_t;

endpackage

### hw/rtl/orcc_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on orcc_pkg for the stage count.
module orcc_isqrt import orcc_pkg::*; (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [33:0] rem_q     [ISQRT_STAGES];
  logic [31:0] root_q    [ISQRT_STAGES];
  logic [63:0] x_q       [ISQRT_STAGES];
  logic [33:0] rem_next  [ISQRT_STAGES];
  logic [31:0] root_next [ISQRT_STAGES];
  logic [63:0] x_next    [ISQRT_STAGES];

  always_comb begin
    logic [33:0] r_src;
    logic [31:0] q_src;
    logic [63:0] x_src;
    logic [35:0] t;
    logic [35:0] trial;
    for (int i = 0; i < ISQRT_STAGES; i++) begin
      if (i == 0) begin
        r_src = '0;
        q_src = '0;
        x_src = radicand;
      end else begin
        r_src = rem_q[i-1];
        q_src = root_q[i-1];
        x_src = x_q[i-1];
      end
      t = {r_src, x_src[63:62]};
      trial = {2'b00, q_src, 2'b01};
      x_next[i] = {x_src[61:0], 2'b00};
      if (t >= trial) begin
        rem_next[i] = 34'(t - trial);
        root_next[i] = {q_src[30:0], 1'b1};
      end else begin
        rem_next[i] = t[33:0];
        root_next[i] = {q_src[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ISQRT_STAGES; i++) begin
      rem_q[i] <= rem_next[i];
      root_q[i] <= root_next[i];
      x_q[i] <= x_next[i];
    end
  end

  assign root = root_q[ISQRT_STAGES-1];

endmodule

### hw/rtl/orcc_div.sv
// Pipelined restoring divider giving floor((num << 32) / den), one bit per stage.
// Depends on orcc_pkg for the stage count and quotient width.
module orcc_div import orcc_pkg::*; (
  input  logic             clk,
  input  logic [15:0]      num,
  input  logic [31:0]      den,
  output logic [QUO_W-1:0] quo
);

  logic [31:0]      rem_q    [DIV_STAGES];
  logic [31:0]      den_q    [DIV_STAGES];
  logic [QUO_W-1:0] quo_q    [DIV_STAGES];
  logic [31:0]      rem_next [DIV_STAGES];
  logic [31:0]      den_next [DIV_STAGES];
  logic [QUO_W-1:0] quo_next [DIV_STAGES];

  always_comb begin
    logic [31:0]      r_src;
    logic [31:0]      d_src;
    logic [QUO_W-1:0] q_src;
    logic [32:0]      t;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        r_src = {1'b0, num, 15'd0};
        d_src = den;
        q_src = '0;
      end else begin
        r_src = rem_q[i-1];
        d_src = den_q[i-1];
        q_src = quo_q[i-1];
      end
      t = {r_src, 1'b0};
      den_next[i] = d_src;
      if (t >= {1'b0, d_src}) begin
        rem_next[i] = 32'(t - {1'b0, d_src});
        quo_next[i] = {q_src[QUO_W-2:0], 1'b1};
      end else begin
        rem_next[i] = t[31:0];
        quo_next[i] = {q_src[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      rem_q[i] <= rem_next[i];
      den_q[i] <= den_next[i];
      quo_q[i] <= quo_next[i];
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

### hw/rtl/orcc_unit.sv
// Heading normalizer: turns a raw heading into a Q.16 unit vector.
// Depends on orcc_pkg, orcc_isqrt and orcc_div.
module orcc_unit import orcc_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  output unit_vec_t          uvec
);

  logic [15:0]      mx;
  logic [15:0]      my;
  logic             nx;
  logic             ny;
  logic             zero;
  logic [31:0]      m2;
  logic [31:0]      root;
  logic [31:0]      mag_pipe  [ISQRT_STAGES];
  logic [2:0]       flag_pipe [SIGN_DLY];
  logic [QUO_W-1:0] qx;
  logic [QUO_W-1:0] qy;
  logic [2:0]       flags;

  always_ff @(posedge clk) begin
    mx <= dir_x[15] ? 16'(~dir_x + 16'sd1) : 16'(dir_x);
    my <= dir_y[15] ? 16'(~dir_y + 16'sd1) : 16'(dir_y);
    nx <= dir_x[15];
    ny <= dir_y[15];
    zero <= (dir_x == 16'sd0) && (dir_y == 16'sd0);
  end

  assign m2 = 32'(mx) * 32'(mx) + 32'(my) * 32'(my);

  orcc_isqrt u_isqrt (
    .clk      (clk),
    .radicand ({m2, 32'd0}),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    mag_pipe[0] <= {mx, my};
    flag_pipe[0] <= {zero, nx, ny};
    for (int i = 1; i < ISQRT_STAGES; i++) mag_pipe[i] <= mag_pipe[i-1];
    for (int i = 1; i < SIGN_DLY; i++) flag_pipe[i] <= flag_pipe[i-1];
  end

  orcc_div u_div_x (
    .clk (clk),
    .num (mag_pipe[ISQRT_STAGES-1][31:16]),
    .den (root),
    .quo (qx)
  );

  orcc_div u_div_y (
    .clk (clk),
    .num (mag_pipe[ISQRT_STAGES-1][15:0]),
    .den (root),
    .quo (qy)
  );

  assign flags = flag_pipe[SIGN_DLY-1];

  always_ff @(posedge clk) begin
    uvec.x_mag <= flags[2] ? UNIT_ONE : qx;
    uvec.x_neg <= !flags[2] && flags[1];
    uvec.y_mag <= flags[2] ? '0 : qy;
    uvec.y_neg <= !flags[2] && flags[0];
  end

endmodule

### hw/rtl/orcc_rect.sv
// Footprint builder: scales the unit heading by half length and half width
// and forms the four corner offsets. Depends on orcc_pkg.
module orcc_rect import orcc_pkg::*; (
  input  logic        clk,
  input  unit_vec_t   uvec,
  input  logic [15:0] wide,
  input  logic [15:0] long,
  output rect_geom_t  geom
);

  logic [32:0]            p_fx;
  logic [32:0]            p_fy;
  logic [32:0]            p_lx;
  logic [32:0]            p_ly;
  logic [HS_W-2:0]        fxm;
  logic [HS_W-2:0]        fym;
  logic [HS_W-2:0]        lxm;
  logic [HS_W-2:0]        lym;
  logic                   x_neg;
  logic                   y_neg;
  logic signed [HS_W-1:0] fx;
  logic signed [HS_W-1:0] fy;
  logic signed [HS_W-1:0] lx;
  logic signed [HS_W-1:0] ly;

  assign p_fx = 33'(uvec.x_mag) * 33'(long);
  assign p_fy = 33'(uvec.y_mag) * 33'(long);
  assign p_lx = 33'(uvec.y_mag) * 33'(wide);
  assign p_ly = 33'(uvec.x_mag) * 33'(wide);

  always_ff @(posedge clk) begin
    fxm <= p_fx[32:9];
    fym <= p_fy[32:9];
    lxm <= p_lx[32:9];
    lym <= p_ly[32:9];
    x_neg <= uvec.x_neg;
    y_neg <= uvec.y_neg;
  end

  always_comb begin
    fx = x_neg ? -$signed({1'b0, fxm}) : $signed({1'b0, fxm});
    fy = y_neg ? -$signed({1'b0, fym}) : $signed({1'b0, fym});
    lx = y_neg ? $signed({1'b0, lxm}) : -$signed({1'b0, lxm});
    ly = x_neg ? -$signed({1'b0, lym}) : $signed({1'b0, lym});
  end

  always_ff @(posedge clk) begin
    geom.cx[0] <= OFF_W'(lx) + OFF_W'(fx);
    geom.cy[0] <= OFF_W'(ly) + OFF_W'(fy);
    geom.cx[1] <= OFF_W'(fx) - OFF_W'(lx);
    geom.cy[1] <= OFF_W'(fy) - OFF_W'(ly);
    geom.cx[2] <= -OFF_W'(lx) - OFF_W'(fx);
    geom.cy[2] <= -OFF_W'(ly) - OFF_W'(fy);
    geom.cx[3] <= OFF_W'(lx) - OFF_W'(fx);
    geom.cy[3] <= OFF_W'(ly) - OFF_W'(fy);
    geom.lx <= lx;
    geom.ly <= ly;
    geom.fx <= fx;
    geom.fy <= fy;
  end

endmodule

### hw/rtl/orcc_inside.sv
// Corner containment test: edge cross products of the second rectangle
// against every corner of the first. Depends on orcc_pkg.
module orcc_inside import orcc_pkg::*; (
  input  logic                     clk,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  input  rect_geom_t               ga,
  input  rect_geom_t               gb,
  output logic                     hit_any
);

  logic signed [DIFF_W-1:0] ax_q [4][4];
  logic signed [DIFF_W-1:0] ay_q [4][4];
  logic signed [OFF_W-1:0]  ex_q [4];
  logic signed [OFF_W-1:0]  ey_q [4];
  logic signed [PROD_W-1:0] p1_q [4][4];
  logic signed [PROD_W-1:0] p2_q [4][4];
  logic                     pos_q [4][4];
  logic                     zer_q [4][4];
  logic signed [OFF_W-1:0]  tlx;
  logic signed [OFF_W-1:0]  tly;
  logic signed [OFF_W-1:0]  tfx;
  logic signed [OFF_W-1:0]  tfy;
  logic [3:0]               ins;

  assign tlx = $signed({gb.lx, 1'b0});
  assign tly = $signed({gb.ly, 1'b0});
  assign tfx = $signed({gb.fx, 1'b0});
  assign tfy = $signed({gb.fy, 1'b0});

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ax_q[i][j] <= dx + DIFF_W'($signed(ga.cx[i])) - DIFF_W'($signed(gb.cx[j]));
        ay_q[i][j] <= dy + DIFF_W'($signed(ga.cy[i])) - DIFF_W'($signed(gb.cy[j]));
      end
    end
    ex_q[0] <= -tlx;
    ey_q[0] <= -tly;
    ex_q[1] <= -tfx;
    ey_q[1] <= -tfy;
    ex_q[2] <= tlx;
    ey_q[2] <= tly;
    ex_q[3] <= tfx;
    ey_q[3] <= tfy;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_q[i][j] <= PROD_W'(ey_q[j]) * PROD_W'(ax_q[i][j]);
        p2_q[i][j] <= PROD_W'(ex_q[j]) * PROD_W'(ay_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pos_q[i][j] <= p1_q[i][j] > p2_q[i][j];
        zer_q[i][j] <= p1_q[i][j] == p2_q[i][j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (zer_q[i][1]) begin
        ins[i] = 1'b1;
      end else if (pos_q[i][1] != pos_q[i][0]) begin
        ins[i] = 1'b0;
      end else if (zer_q[i][2]) begin
        ins[i] = 1'b1;
      end else if (pos_q[i][2] != pos_q[i][0]) begin
        ins[i] = 1'b0;
      end else if (zer_q[i][3]) begin
        ins[i] = 1'b1;
      end else begin
        ins[i] = pos_q[i][3] == pos_q[i][0];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_any <= |ins;
  end

endmodule

### hw/rtl/orcc_near.sv
// Coarse test: exact check that the center distance is below the sum of the
// two half-diagonals, spread over six stages. Depends on orcc_pkg.
module orcc_near import orcc_pkg::*; (
  input  logic     clk,
  input  in_item_t item,
  output logic     near
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        mx;
  logic [32:0]        my;
  logic               far1;
  logic [24:0]        mdx1;
  logic [24:0]        mdy1;
  logic [32:0]        sa1;
  logic [32:0]        sb1;
  logic               far2;
  logic [50:0]        d2;
  logic [32:0]        sa2;
  logic [32:0]        sb2;
  logic [47:0]        rsum;
  logic               far3;
  logic               less3;
  logic [50:0]        s3;
  logic [32:0]        sa3;
  logic [32:0]        sb3;
  logic               far4;
  logic               less4;
  logic [49:0]        ss11;
  logic [50:0]        ss10;
  logic [51:0]        ss00;
  logic [31:0]        ab11;
  logic [32:0]        ab10;
  logic [32:0]        ab01;
  logic [33:0]        ab00;
  logic [65:0]        ab;
  logic               far5;
  logic               less5;
  logic [101:0]       sq5;
  logic [95:0]        rr5;

  always_comb begin
    dx = 33'(item.a_pos_x) - 33'(item.b_pos_x);
    dy = 33'(item.a_pos_y) - 33'(item.b_pos_y);
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
  end

  always_ff @(posedge clk) begin
    far1 <= (|mx[32:25]) || (|my[32:25]);
    mdx1 <= mx[24:0];
    mdy1 <= my[24:0];
    sa1 <= 33'(item.a_long) * 33'(item.a_long) + 33'(item.a_wide) * 33'(item.a_wide);
    sb1 <= 33'(item.b_long) * 33'(item.b_long) + 33'(item.b_wide) * 33'(item.b_wide);
  end

  always_ff @(posedge clk) begin
    far2 <= far1;
    d2 <= 51'(mdx1) * 51'(mdx1) + 51'(mdy1) * 51'(mdy1);
    sa2 <= sa1;
    sb2 <= sb1;
  end

  assign rsum = {34'(sa2) + 34'(sb2), 14'd0};

  always_ff @(posedge clk) begin
    far3 <= far2;
    less3 <= d2 < {3'd0, rsum};
    s3 <= d2 - {3'd0, rsum};
    sa3 <= sa2;
    sb3 <= sb2;
  end

  always_ff @(posedge clk) begin
    far4 <= far3;
    less4 <= less3;
    ss11 <= 50'(s3[50:26]) * 50'(s3[50:26]);
    ss10 <= 51'(s3[50:26]) * 51'(s3[25:0]);
    ss00 <= 52'(s3[25:0]) * 52'(s3[25:0]);
    ab11 <= 32'(sa3[32:17]) * 32'(sb3[32:17]);
    ab10 <= 33'(sa3[32:17]) * 33'(sb3[16:0]);
    ab01 <= 33'(sa3[16:0]) * 33'(sb3[32:17]);
    ab00 <= 34'(sa3[16:0]) * 34'(sb3[16:0]);
  end

  assign ab = {ab11, 34'd0} + {15'd0, 34'(ab10) + 34'(ab01), 17'd0} + {32'd0, ab00};

  always_ff @(posedge clk) begin
    far5 <= far4;
    less5 <= less4;
    sq5 <= {ss11, 52'd0} + {24'd0, ss10, 27'd0} + {50'd0, ss00};
    rr5 <= {ab, 30'd0};
  end

  always_ff @(posedge clk) begin
    near <= !far5 && (less5 || (sq5 < {6'd0, rr5}));
  end

endmodule

### hw/rtl/oriented_rect_collision_check_core.sv
// Top level of the oriented rectangle collision check core.
// Depends on orcc_pkg, orcc_unit, orcc_rect, orcc_inside and orcc_near.

// The core takes one item, a pair of rectangles, in every clock cycle and never
// raises busy. Each item yields one result on result, marked by done for a single
// cycle; results leave in the order items came in. Each item passes through the
// heading normalizer, a 32-stage square root followed by a 17-stage divider, then
// the corner, cross-product and output stages. The receiver must take every
// result in the cycle it is shown.
module oriented_rect_collision_check_core import orcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      done,
  output out_item_t result
);

  logic [HIT_LAT-1:0]       vld;
  unit_vec_t                ua;
  unit_vec_t                ub;
  logic [63:0]              sz_pipe   [UNIT_LAT];
  logic [2*DIFF_W-1:0]      d_pipe    [D_DLY];
  logic                     near_pipe [NEAR_DLY];
  rect_geom_t               ga;
  rect_geom_t               gb;
  logic                     near_now;
  logic                     hit_any;
  logic signed [DIFF_W-1:0] ddx;
  logic signed [DIFF_W-1:0] ddy;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[HIT_LAT-2:0], start && !busy};
      done <= vld[HIT_LAT-1];
    end
  end

  orcc_unit u_unit_a (
    .clk   (clk),
    .dir_x (item.a_dir_x),
    .dir_y (item.a_dir_y),
    .uvec  (ua)
  );

  orcc_unit u_unit_b (
    .clk   (clk),
    .dir_x (item.b_dir_x),
    .dir_y (item.b_dir_y),
    .uvec  (ub)
  );

  always_ff @(posedge clk) begin
    sz_pipe[0] <= {item.a_wide, item.a_long, item.b_wide, item.b_long};
    for (int i = 1; i < UNIT_LAT; i++) sz_pipe[i] <= sz_pipe[i-1];
    d_pipe[0] <= {DIFF_W'(item.a_pos_x - item.b_pos_x),
                  DIFF_W'(item.a_pos_y - item.b_pos_y)};
    for (int i = 1; i < D_DLY; i++) d_pipe[i] <= d_pipe[i-1];
    near_pipe[0] <= near_now;
    for (int i = 1; i < NEAR_DLY; i++) near_pipe[i] <= near_pipe[i-1];
  end

  orcc_rect u_rect_a (
    .clk  (clk),
    .uvec (ua),
    .wide (sz_pipe[UNIT_LAT-1][63:48]),
    .long (sz_pipe[UNIT_LAT-1][47:32]),
    .geom (ga)
  );

  orcc_rect u_rect_b (
    .clk  (clk),
    .uvec (ub),
    .wide (sz_pipe[UNIT_LAT-1][31:16]),
    .long (sz_pipe[UNIT_LAT-1][15:0]),
    .geom (gb)
  );

  assign ddx = $signed(d_pipe[D_DLY-1][2*DIFF_W-1:DIFF_W]);
  assign ddy = $signed(d_pipe[D_DLY-1][DIFF_W-1:0]);

  orcc_inside u_inside (
    .clk     (clk),
    .dx      (ddx),
    .dy      (ddy),
    .ga      (ga),
    .gb      (gb),
    .hit_any (hit_any)
  );

  orcc_near u_near (
    .clk  (clk),
    .item (item),
    .near (near_now)
  );

  always_ff @(posedge clk) begin
    result.near <= near_pipe[NEAR_DLY-1];
    result.hit <= near_pipe[NEAR_DLY-1] && hit_any;
  end

  a_hit_needs_near: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.near || !result.hit))
    else $error("hit reported without near");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result without an item taken at the expected cycle");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> $past(start))
    else $error("pipeline valid without an item");

endmodule

### tb/oriented_rect_collision_check_core_tb.sv
// Self-checking testbench for oriented_rect_collision_check_core.
// It predicts hit and near for every rectangle pair it sends and checks each result.
// Depends on orcc_pkg and the core RTL only.
module oriented_rect_collision_check_core_tb;
  import orcc_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      done;
  out_item_t result;

  in_item_t  pending_pairs[$];
  out_item_t expected_verdicts[$];
  int        mismatches = 0;
  int        sent_n = 0;
  int        checked_n = 0;
  int        hits_n = 0;
  int        nears_n = 0;
  int        gap_left = 0;
  int        directed_n = 0;
  int        calm_until = 0;
  bit        took = 1'b0;
  bit        stim_done = 1'b0;

  oriented_rect_collision_check_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void heading(input longint dx, input longint dy,
                                  output longint ux, output longint uy);
    longint unsigned mx, my, n;
    mx = magn(dx);
    my = magn(dy);
    if (mx == 0 && my == 0) begin
      ux = 65536;
      uy = 0;
    end else begin
      n = root64((mx * mx + my * my) << 32);
      ux = longint'((mx << 32) / n);
      uy = longint'((my << 32) / n);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
    end
  endfunction

  function automatic longint half_off(longint u, longint unsigned s);
    longint unsigned p;
    p = (magn(u) * s) >> 9;
    return (u < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void footprint(input longint px, input longint py,
                                    input longint dx, input longint dy,
                                    input longint unsigned w, input longint unsigned l,
                                    output longint cx[4], output longint cy[4]);
    longint ux, uy, fx, fy, lx, ly;
    heading(dx, dy, ux, uy);
    fx = half_off(ux, l);
    fy = half_off(uy, l);
    lx = -half_off(uy, w);
    ly = half_off(ux, w);
    cx[0] = px + lx + fx; cy[0] = py + ly + fy;
    cx[1] = px - lx + fx; cy[1] = py - ly + fy;
    cx[2] = px - lx - fx; cy[2] = py - ly - fy;
    cx[3] = px + lx - fx; cy[3] = py + ly - fy;
  endfunction

  function automatic bit corner_in(longint qx, longint qy, longint cx[4], longint cy[4]);
    bit sgn0, pos;
    longint bx, by, ax, ay, z;
    sgn0 = 1'b0;
    for (int j = 0; j < 4; j++) begin
      bx = cx[(j + 1) & 3] - cx[j];
      by = cy[(j + 1) & 3] - cy[j];
      ax = qx - cx[j];
      ay = qy - cy[j];
      z = by * ax - bx * ay;
      pos = z > 0;
      if (j == 0) sgn0 = pos;
      else if (z == 0) return 1'b1;
      else if (pos != sgn0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit circles_overlap(longint dx, longint dy,
                                         longint unsigned ra2, longint unsigned rb2);
    longint unsigned mx, my, d2, s;
    logic [127:0] s2, r4;
    mx = magn(dx);
    my = magn(dy);
    if (mx >= 64'd33554432 || my >= 64'd33554432) return 1'b0;
    d2 = mx * mx + my * my;
    if (d2 < ra2 + rb2) return 1'b1;
    s = d2 - ra2 - rb2;
    s2 = {64'd0, s} * {64'd0, s};
    r4 = ({64'd0, ra2} * {64'd0, rb2}) << 2;
    return s2 < r4;
  endfunction

  function automatic out_item_t collision_verdict(in_item_t p);
    out_item_t v;
    longint apx, apy, bpx, bpy;
    longint unsigned aw, al, bw, bl, ra2, rb2;
    longint acx[4], acy[4], bcx[4], bcy[4];
    apx = longint'($signed(p.a_pos_x));
    apy = longint'($signed(p.a_pos_y));
    bpx = longint'($signed(p.b_pos_x));
    bpy = longint'($signed(p.b_pos_y));
    aw = 64'(p.a_wide); al = 64'(p.a_long); bw = 64'(p.b_wide); bl = 64'(p.b_long);
    ra2 = (128 * al) * (128 * al) + (128 * aw) * (128 * aw);
    rb2 = (128 * bl) * (128 * bl) + (128 * bw) * (128 * bw);
    v.near = circles_overlap(apx - bpx, apy - bpy, ra2, rb2);
    v.hit = 1'b0;
    if (v.near) begin
      footprint(apx, apy, longint'($signed(p.a_dir_x)), longint'($signed(p.a_dir_y)),
                aw, al, acx, acy);
      footprint(bpx, bpy, longint'($signed(p.b_dir_x)), longint'($signed(p.b_dir_y)),
                bw, bl, bcx, bcy);
      for (int i = 0; i < 4 && !v.hit; i++) v.hit = corner_in(acx[i], acy[i], bcx, bcy);
    end
    return v;
  endfunction

  function automatic in_item_t pair(int apx, int apy, int adx, int ady, int aw, int al,
                                   int bpx, int bpy, int bdx, int bdy, int bw, int bl);
    in_item_t p;
    p.a_pos_x = apx; p.a_pos_y = apy; p.a_dir_x = 16'(adx); p.a_dir_y = 16'(ady);
    p.a_wide = 16'(aw); p.a_long = 16'(al);
    p.b_pos_x = bpx; p.b_pos_y = bpy; p.b_dir_x = 16'(bdx); p.b_dir_y = 16'(bdy);
    p.b_wide = 16'(bw); p.b_long = 16'(bl);
    return p;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 2047));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t close_pair();
    in_item_t p;
    int k;
    p = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom});
    p.a_dir_x = rand_dir(); p.a_dir_y = rand_dir();
    p.b_dir_x = rand_dir(); p.b_dir_y = rand_dir();
    p.a_wide = rand_size(); p.a_long = rand_size();
    p.b_wide = rand_size(); p.b_long = rand_size();
    k = $urandom_range(0, 25);
    p.b_pos_x = p.a_pos_x + ($signed($urandom) >>> (31 - k));
    p.b_pos_y = p.a_pos_y + ($signed($urandom) >>> (31 - k));
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_verdicts.push_back(collision_verdict(item));
        sent_n++;
        took = 1'b1;
      end
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result hit=%0b near=%0b",
                                         result.hit, result.near);
        end else begin
          out_item_t want;
          want = expected_verdicts.pop_front();
          checked_n++;
          hits_n += int'(want.hit);
          nears_n += int'(want.near);
          if (result.hit !== want.hit || result.near !== want.near) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected hit=%0b near=%0b, got hit=%0b near=%0b",
                       checked_n, want.hit, want.near, result.hit, result.near);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && !(start && !took)) begin
      took = 1'b0;
      if (sent_n >= calm_until && $urandom_range(0, 99) == 0) calm_until = sent_n + 100;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if ((sent_n == directed_n || sent_n == 1000) && expected_verdicts.size() != 0) begin
        start <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        item <= pending_pairs.pop_front();
        start <= 1'b1;
        gap_left = (sent_n < calm_until) ? 0 : $urandom_range(0, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    pending_pairs.push_back(pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pair(0, 0, 0, 0, 16'hFFFF, 16'hFFFF,
                                 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    pending_pairs.push_back(pair(0, 0, -32768, -32768, 256, 512, 100, 0, 32767, 32767, 512, 256));
    pending_pairs.push_back(pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32767, -32768, 16'hFFFF, 16'hFFFF,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, -32768, 32767, 16'hFFFF, 16'hFFFF));
    pending_pairs.push_back(pair(32'h80000000, 32'h80000000, 1, 0, 256, 256,
                                 32'h80000000, 32'h80000000, 0, 1, 256, 256));
    pending_pairs.push_back(pair(32'h7FFFFFFF, 0, 1, 1, 16'hFFFF, 16'hFFFF,
                                 32'h80000000, 0, 1, 1, 16'hFFFF, 16'hFFFF));
    pending_pairs.push_back(pair(0, 0, 3, 4, 128, 256, 0, 0, 3, 4, 128, 256));
    pending_pairs.push_back(pair(1000, 2000, 1, 0, 10, 10, 0, 0, 0, 1, 2560, 2560));
    pending_pairs.push_back(pair(1000, 0, 1, 2, 512, 512, 0, 0, 5, 0, 0, 0));
    pending_pairs.push_back(pair(0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 512, 512));
    pending_pairs.push_back(pair(0, 0, 1, 0, 0, 0, 500, 300, 1, 0, 512, 512));
    pending_pairs.push_back(pair(0, 0, 1, 0, 0, 1000, 128000, 0, 1, 0, 0, 0));
    pending_pairs.push_back(pair(0, 0, 1, 0, 0, 1000, 127999, 0, 1, 0, 0, 0));
    pending_pairs.push_back(pair(0, 0, 0, 1, 0, 0, 33554432, 0, 0, 1, 16'hFFFF, 16'hFFFF));
    pending_pairs.push_back(pair(0, 0, 0, 1, 0, 0, 33554431, 0, 0, 1, 16'hFFFF, 16'hFFFF));
    pending_pairs.push_back(pair(0, 0, 1, 0, 256, 256, 0, 65536, 1, 0, 256, 256));
    pending_pairs.push_back(pair(0, 0, 1, 1, 512, 512, 65536, 0, -1, 1, 512, 512));
    pending_pairs.push_back(pair(-5000, 7000, -3, 0, 1024, 64, -5000, 7000, 0, -7, 64, 1024));
    pending_pairs.push_back(pair(0, 0, 0, 0, 300, 300, 65536, 65536, 0, 0, 300, 300));
    pending_pairs.push_back(pair(0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    directed_n = pending_pairs.size();
    for (int n = 0; n < 1950; n++) begin
      if ($urandom_range(0, 9) < 8) pending_pairs.push_back(close_pair());
      else pending_pairs.push_back(in_item_t'({$urandom, $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom, $urandom}));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_pairs.size() != 0 || start) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
    $display("Sent %0d rectangle pairs and checked %0d results,", sent_n, checked_n);
    $display("of which %0d were near and %0d hit.", nears_n, hits_n);
    if (mismatches == 0) begin
      $display("oriented_rect_collision_check_core_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("oriented_rect_collision_check_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("oriented_rect_collision_check_core_tb: errors");
    $finish;
  end

endmodule

### oriented_rect_collision_check_core.f
hw/rtl/orcc_pkg.sv
hw/rtl/orcc_isqrt.sv
hw/rtl/orcc_div.sv
hw/rtl/orcc_unit.sv
hw/rtl/orcc_rect.sv
hw/rtl/orcc_inside.sv
hw/rtl/orcc_near.sv
hw/rtl/oriented_rect_collision_check_core.sv
tb/oriented_rect_collision_check_core_tb.sv
